// ----- rtl/btg_pkg.sv -----
package btg_pkg;

  localparam int TPM_W    = 10;
  localparam int PER_W    = 20;
  localparam int HALF_W   = 19;
  localparam int HIGH_W   = 19;
  localparam int CNT_W    = 26;
  localparam int VOL_W    = 7;
  localparam int DIV_NW   = 26;
  localparam int DIV_DW   = 20;
  localparam int MS_SCALE = 1000;
  localparam int VOL_MAX  = 100;

  // ceil(2^32 / 100): exact division by 100 for products below 2^30
  localparam int               VOL_RECIP_SH = 32;
  localparam logic [CNT_W-1:0] VOL_RECIP    = CNT_W'(42949673);

  localparam logic [TPM_W-1:0] TPM_RESET = TPM_W'(1000);

  typedef struct packed {
    logic        req_type;
    logic [15:0] frequency;
    logic [15:0] dur_ms;
    logic [7:0]  volume;
  } req_t;

  typedef struct packed {
    logic buzzer_level;
    logic busy_res;
    logic tone_done;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_P_GO,
    ST_P_WAIT,
    ST_CHECK,
    ST_H_GO,
    ST_C_GO,
    ST_C_WAIT,
    ST_RESULT
  } ctrl_state_t;

  typedef enum logic [1:0] {
    DIV_PERIOD,
    DIV_CYCLES
  } div_sel_t;

  typedef struct packed {
    logic     cfg_wr;
    logic     capture;
    logic     tick;
    logic     div_start;
    div_sel_t div_sel;
    logic     load_period;
    logic     load_hv;
    logic     load_silence;
    logic     load_high;
    logic     load_tone;
    logic     load_out;
    logic     out_start;
  } dp_cmd_t;

  typedef struct packed {
    logic freq_zero;
    logic silent;
    logic div_done;
  } dp_status_t;

endpackage

// ----- rtl/buzzer_tone_generator_top.sv -----
// Tick transfer: result registered in the cycle after acceptance, one tick per
// cycle while the result output is not stalled. Start transfer: result after two
// 26-step serial divisions (period, cycle count) on one shared divider, requests
// stalled meanwhile; silent tones do only the period division, a zero frequency none.
// Synchronous active-high reset: idle, no tone running, ticks_per_ms = 1000.
module buzzer_tone_generator_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  btg_pkg::req_t             req,
  output logic                      rsp_valid,
  input  logic                      rsp_stall,
  output btg_pkg::rsp_t             rsp,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [btg_pkg::TPM_W-1:0] cfg_data
);

  btg_pkg::dp_cmd_t    cmd;
  btg_pkg::dp_status_t status;

  btg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_start (req.req_type),
    .rsp_stall (rsp_stall),
    .cfg_valid (cfg_valid),
    .status    (status),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  btg_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .status   (status),
    .rsp      (rsp)
  );

endmodule

// ----- rtl/btg_div.sv -----
module btg_div #(
  parameter int NW = btg_pkg::DIV_NW,
  parameter int DW = btg_pkg::DIV_DW
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);

  localparam int CW = $clog2(NW + 1);

  logic [CW-1:0] cnt;
  logic [DW-1:0] den_r;
  logic [DW-1:0] rem;
  logic [NW-1:0] q;
  logic [DW:0]   rem_sh;
  logic [DW:0]   diff;
  logic          fit;

  always_comb begin
    rem_sh = {rem, q[NW-1]};
    diff   = rem_sh - {1'b0, den_r};
    fit    = rem_sh >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      cnt  <= CW'(NW);
      done <= 1'b0;
    end else begin
      done <= cnt == CW'(1);
      if (cnt != '0) begin
        cnt <= cnt - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      rem   <= '0;
      q     <= num;
    end else if (cnt != '0) begin
      rem <= fit ? diff[DW-1:0] : rem_sh[DW-1:0];
      q   <= {q[NW-2:0], fit};
    end
  end

  assign quo = q;

endmodule

// ----- rtl/btg_dp.sv -----
module btg_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  btg_pkg::req_t                      req,
  input  logic [btg_pkg::TPM_W-1:0]          cfg_data,
  input  btg_pkg::dp_cmd_t                   cmd,
  output btg_pkg::dp_status_t                status,
  output btg_pkg::rsp_t                      rsp
);

  logic [btg_pkg::TPM_W-1:0]  tpm;
  logic                       freq_zero;
  logic [15:0]                freq;
  logic [btg_pkg::VOL_W-1:0]  vol;
  logic [btg_pkg::PER_W-1:0]  n_scaled;
  logic [btg_pkg::CNT_W-1:0]  dur_ticks;
  logic [btg_pkg::PER_W-1:0]  period;
  logic [btg_pkg::CNT_W-1:0]  hv;
  logic [btg_pkg::HIGH_W-1:0] high_ticks;
  logic [btg_pkg::PER_W-1:0]  cycle_ticks;
  logic [btg_pkg::PER_W-1:0]  tick_in_cycle;
  logic [btg_pkg::CNT_W-1:0]  cycles_left;
  logic [btg_pkg::CNT_W-1:0]  silence_left;
  logic                       running;
  btg_pkg::rsp_t              rsp_r;

  logic [btg_pkg::HALF_W-1:0] half;
  logic [btg_pkg::VOL_W-1:0]  vol_next;
  logic [btg_pkg::PER_W-1:0]  n_scaled_next;
  logic [btg_pkg::CNT_W-1:0]  dur_ticks_next;
  logic [btg_pkg::CNT_W-1:0]  hv_next;
  logic [2*btg_pkg::CNT_W-1:0] hv_scaled;

  logic [btg_pkg::DIV_NW-1:0] div_num;
  logic [btg_pkg::DIV_DW-1:0] div_den;
  logic                       div_done;
  logic [btg_pkg::DIV_NW-1:0] div_quo;

  logic [btg_pkg::CNT_W-1:0]  sil_dec;
  logic [btg_pkg::CNT_W-1:0]  cyc_dec;
  logic [btg_pkg::PER_W:0]    tic_inc;
  logic                       t_level;
  logic                       t_done;
  logic                       t_running;
  logic [btg_pkg::CNT_W-1:0]  t_sil;
  logic [btg_pkg::CNT_W-1:0]  t_cyc;
  logic [btg_pkg::PER_W-1:0]  t_tic;

  assign half           = period[btg_pkg::PER_W-1:1];
  assign vol_next       = (req.volume > 8'(btg_pkg::VOL_MAX)) ?
                          btg_pkg::VOL_W'(btg_pkg::VOL_MAX) : req.volume[btg_pkg::VOL_W-1:0];
  assign n_scaled_next  = btg_pkg::PER_W'(tpm) * btg_pkg::PER_W'(btg_pkg::MS_SCALE);
  assign dur_ticks_next = btg_pkg::CNT_W'(req.dur_ms) * btg_pkg::CNT_W'(tpm);
  assign hv_next        = btg_pkg::CNT_W'(half) * btg_pkg::CNT_W'(vol);
  assign hv_scaled      = (2*btg_pkg::CNT_W)'(hv) * (2*btg_pkg::CNT_W)'(btg_pkg::VOL_RECIP);

  always_comb begin
    unique case (cmd.div_sel)
      btg_pkg::DIV_CYCLES: begin
        div_num = dur_ticks;
        div_den = period;
      end
      default: begin
        div_num = btg_pkg::DIV_NW'(n_scaled);
        div_den = btg_pkg::DIV_DW'(freq);
      end
    endcase
  end

  btg_div #(
    .NW (btg_pkg::DIV_NW),
    .DW (btg_pkg::DIV_DW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    sil_dec   = silence_left - btg_pkg::CNT_W'(1);
    cyc_dec   = cycles_left - btg_pkg::CNT_W'(1);
    tic_inc   = {1'b0, tick_in_cycle} + (btg_pkg::PER_W+1)'(1);
    t_level   = 1'b0;
    t_done    = 1'b0;
    t_running = running;
    t_sil     = silence_left;
    t_cyc     = cycles_left;
    t_tic     = tick_in_cycle;
    if (running) begin
      if (cycles_left == '0) begin
        t_sil = sil_dec;
        if (sil_dec == '0) begin
          t_running = 1'b0;
          t_done    = 1'b1;
        end
      end else begin
        t_level = tick_in_cycle < btg_pkg::PER_W'(high_ticks);
        if (tic_inc >= {1'b0, cycle_ticks}) begin
          t_tic = '0;
          t_cyc = cyc_dec;
          if (cyc_dec == '0) begin
            t_running = 1'b0;
            t_done    = 1'b1;
          end
        end else begin
          t_tic = tic_inc[btg_pkg::PER_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tpm     <= btg_pkg::TPM_RESET;
      running <= 1'b0;
    end else begin
      if (cmd.cfg_wr) begin
        tpm <= cfg_data;
      end
      if (cmd.tick) begin
        running <= t_running;
      end else if (cmd.load_silence) begin
        running <= dur_ticks != '0;
      end else if (cmd.load_tone) begin
        running <= div_quo != '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      freq      <= req.frequency;
      freq_zero <= req.frequency == '0;
      vol       <= vol_next;
      n_scaled  <= n_scaled_next;
      dur_ticks <= dur_ticks_next;
      period    <= '0;
    end
    if (cmd.load_period) begin
      period <= div_quo[btg_pkg::PER_W-1:0];
    end
    if (cmd.load_hv) begin
      hv <= hv_next;
    end
    if (cmd.load_high) begin
      high_ticks <= hv_scaled[btg_pkg::VOL_RECIP_SH +: btg_pkg::HIGH_W];
    end
    if (cmd.tick) begin
      silence_left  <= t_sil;
      cycles_left   <= t_cyc;
      tick_in_cycle <= t_tic;
    end else if (cmd.load_silence) begin
      high_ticks    <= '0;
      cycle_ticks   <= '0;
      cycles_left   <= '0;
      silence_left  <= dur_ticks;
      tick_in_cycle <= '0;
    end else if (cmd.load_tone) begin
      cycle_ticks   <= {half, 1'b0};
      cycles_left   <= div_quo;
      silence_left  <= '0;
      tick_in_cycle <= '0;
    end
    if (cmd.load_out) begin
      if (cmd.out_start) begin
        rsp_r <= '{buzzer_level: 1'b0, busy_res: running, tone_done: 1'b0};
      end else begin
        rsp_r <= '{buzzer_level: t_level, busy_res: t_running, tone_done: t_done};
      end
    end
  end

  assign status.freq_zero = freq_zero;
  assign status.silent    = freq_zero || (vol == '0) || (half == '0);
  assign status.div_done  = div_done;
  assign rsp              = rsp_r;

endmodule

// ----- rtl/btg_ctrl.sv -----
module btg_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  logic                req_start,
  input  logic                rsp_stall,
  input  logic                cfg_valid,
  input  btg_pkg::dp_status_t status,
  output logic                req_stall,
  output logic                rsp_valid,
  output logic                cfg_ready,
  output btg_pkg::dp_cmd_t    cmd
);

  btg_pkg::ctrl_state_t state;
  btg_pkg::ctrl_state_t state_next;

  logic out_free;
  logic accept;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign accept    = req_valid && (state == btg_pkg::ST_IDLE) && out_free;
  assign req_stall = !((state == btg_pkg::ST_IDLE) && out_free);
  assign cfg_ready = state == btg_pkg::ST_IDLE;

  always_comb begin
    state_next = state;
    unique case (state)
      btg_pkg::ST_IDLE: begin
        if (accept && req_start) begin
          state_next = btg_pkg::ST_P_GO;
        end
      end
      btg_pkg::ST_P_GO: begin
        state_next = status.freq_zero ? btg_pkg::ST_CHECK : btg_pkg::ST_P_WAIT;
      end
      btg_pkg::ST_P_WAIT: begin
        if (status.div_done) begin
          state_next = btg_pkg::ST_CHECK;
        end
      end
      btg_pkg::ST_CHECK: begin
        state_next = status.silent ? btg_pkg::ST_RESULT : btg_pkg::ST_H_GO;
      end
      btg_pkg::ST_H_GO: begin
        state_next = btg_pkg::ST_C_GO;
      end
      btg_pkg::ST_C_GO: begin
        state_next = btg_pkg::ST_C_WAIT;
      end
      btg_pkg::ST_C_WAIT: begin
        if (status.div_done) begin
          state_next = btg_pkg::ST_RESULT;
        end
      end
      btg_pkg::ST_RESULT: begin
        if (out_free) begin
          state_next = btg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = btg_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.div_sel = btg_pkg::DIV_PERIOD;
    cmd.cfg_wr  = cfg_valid && cfg_ready;
    unique case (state)
      btg_pkg::ST_IDLE: begin
        cmd.capture  = accept && req_start;
        cmd.tick     = accept && !req_start;
        cmd.load_out = accept && !req_start;
      end
      btg_pkg::ST_P_GO: begin
        cmd.div_start = !status.freq_zero;
      end
      btg_pkg::ST_P_WAIT: begin
        cmd.load_period = status.div_done;
      end
      btg_pkg::ST_CHECK: begin
        cmd.load_silence = status.silent;
        cmd.load_hv      = !status.silent;
      end
      btg_pkg::ST_H_GO: begin
        cmd.load_high = 1'b1;
      end
      btg_pkg::ST_C_GO: begin
        cmd.div_sel   = btg_pkg::DIV_CYCLES;
        cmd.div_start = 1'b1;
      end
      btg_pkg::ST_C_WAIT: begin
        cmd.div_sel   = btg_pkg::DIV_CYCLES;
        cmd.load_tone = status.div_done;
      end
      btg_pkg::ST_RESULT: begin
        cmd.load_out  = out_free;
        cmd.out_start = 1'b1;
      end
      default: begin
        cmd.div_sel = btg_pkg::DIV_PERIOD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= btg_pkg::ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/btg_chk.sv -----
module btg_chk (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input btg_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input btg_pkg::rsp_t rsp
);

  assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled result dropped or changed");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.tone_done && rsp.busy_res))
    else $error("tone done while still busy");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.buzzer_level |-> rsp.busy_res)
    else $error("buzzer driven with no tone running");

  assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && req.req_type |=> req_stall)
    else $error("transfer taken during tone setup");

endmodule

bind buzzer_tone_generator_top btg_chk u_chk (.*);
